### src/mspc_pkg.sv
package mspc_pkg;

  // Event kinds carried by an input beat.
  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_RESPONSE = 2'd1,
    MODE_POLL     = 2'd2
  } mode_e;

  // Kinds of result beats.
  typedef enum logic [1:0] {
    KIND_TX_BYTE   = 2'd0,
    KIND_READING   = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kind_e;

  // Outstanding request on the bus.
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_PPM  = 2'd1,
    CMD_SCAN = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TIMEOUT_MS      = 3'd0,
    CFG_EXPECTED_HEADER = 3'd1,
    CFG_SENSOR_ENABLED  = 3'd2,
    CFG_POLL_FAIL_LIMIT = 3'd3,
    CFG_SCAN_LIMIT      = 3'd4
  } cfg_idx_e;

  // What a handled event leaves to be sent out.
  typedef enum logic [1:0] {
    JOB_NONE      = 2'd0,
    JOB_FRAME     = 2'd1,
    JOB_READING   = 2'd2,
    JOB_NOT_FOUND = 2'd3
  } job_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
  localparam logic [7:0]  HEADER_RST      = 8'h15;
  localparam logic [7:0]  POLL_LIMIT_RST  = 8'd5;
  localparam logic [7:0]  SCAN_LIMIT_RST  = 8'd255;
  localparam logic [7:0]  SLAVE_ADDR_RST  = 8'h15;

  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [15:0] REG_PPM         = 16'h138B;
  localparam logic [15:0] REG_FIRMWARE    = 16'h1389;
  localparam logic [15:0] REG_COUNT       = 16'h0001;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] resp_address;
    logic [7:0] resp_value_high;
    logic [7:0] resp_value_low;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] reading;
    logic        warning;
  } out_item_t;

  typedef struct packed {
    job_e        op;
    logic [7:0]  addr;
    logic        fw;
    logic [15:0] reading;
    logic        warning;
  } job_t;

  // Full CRC of a request frame; evaluated only at elaboration.
  function automatic logic [15:0] crc16_frame(input logic [7:0] addr,
                                              input logic [15:0] regv);
    logic [5:0][7:0] bytes;
    logic [15:0]     crc;
    bytes[0] = addr;
    bytes[1] = FUNC_READ_INPUT;
    bytes[2] = regv[15:8];
    bytes[3] = regv[7:0];
    bytes[4] = REG_COUNT[15:8];
    bytes[5] = REG_COUNT[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc ^ {8'h00, bytes[i]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  // The CRC is affine in the address byte: one column per address bit.
  function automatic logic [7:0][15:0] crc_addr_cols();
    logic [7:0][15:0] cols;
    for (int i = 0; i < 8; i++) begin
      cols[i] = crc16_frame(8'(1 << i), REG_PPM) ^ crc16_frame(8'h00, REG_PPM);
    end
    return cols;
  endfunction

  localparam logic [15:0]      CRC_BASE_PPM = crc16_frame(8'h00, REG_PPM);
  localparam logic [15:0]      CRC_BASE_FW  = crc16_frame(8'h00, REG_FIRMWARE);
  localparam logic [7:0][15:0] CRC_ADDR_COL = crc_addr_cols();

  function automatic logic [15:0] crc_addr_term(input logic [7:0] addr);
    logic [15:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc = acc ^ (addr[i] ? CRC_ADDR_COL[i] : 16'h0000);
    end
    return acc;
  endfunction

endpackage

### src/mspc_if.sv
interface mspc_in_if;
  logic                 valid;
  logic                 ready;
  mspc_pkg::in_item_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mspc_out_if;
  logic                 valid;
  logic                 ready;
  mspc_pkg::out_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/mspc_ctrl.sv
// Poll state and configuration. Each accepted event updates the state in
// one step and hands any resulting job description to the frame sender.
module mspc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mspc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mspc_pkg::CfgDataW-1:0]   cfg_data_i,
  mspc_in_if.sink                         rx,
  input  logic                            slot_free_i,
  output logic                            job_vld_o,
  output mspc_pkg::job_t                  job_o
);

  logic [15:0]    timeout_q;
  logic [7:0]     header_q;
  logic           enabled_q;
  logic [7:0]     poll_limit_q;
  logic [7:0]     scan_limit_q;

  mspc_pkg::cmd_e pend_q, pend_d;
  logic [15:0]    elapsed_q, elapsed_d;
  logic [7:0]     fail_q, fail_d;
  logic [7:0]     slave_q, slave_d;
  logic           warn_q, warn_d;

  logic           fire;
  logic [15:0]    elapsed_inc;
  logic [7:0]     fail_inc;
  logic           pend_active;
  mspc_pkg::job_e op;
  logic           fw;
  logic [15:0]    reading;

  assign rx.ready = slot_free_i;
  assign fire     = rx.valid && rx.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= mspc_pkg::TIMEOUT_RST;
      header_q     <= mspc_pkg::HEADER_RST;
      enabled_q    <= 1'b1;
      poll_limit_q <= mspc_pkg::POLL_LIMIT_RST;
      scan_limit_q <= mspc_pkg::SCAN_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mspc_pkg::CFG_TIMEOUT_MS:      timeout_q    <= cfg_data_i[15:0];
        mspc_pkg::CFG_EXPECTED_HEADER: header_q     <= cfg_data_i[7:0];
        mspc_pkg::CFG_SENSOR_ENABLED:  enabled_q    <= cfg_data_i[0];
        mspc_pkg::CFG_POLL_FAIL_LIMIT: poll_limit_q <= cfg_data_i[7:0];
        mspc_pkg::CFG_SCAN_LIMIT:      scan_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign fail_inc    = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;
  assign pend_active = (pend_q == mspc_pkg::CMD_PPM) || (pend_q == mspc_pkg::CMD_SCAN);

  always_comb begin
    pend_d    = pend_q;
    elapsed_d = elapsed_q;
    fail_d    = fail_q;
    slave_d   = slave_q;
    warn_d    = warn_q;
    op        = mspc_pkg::JOB_NONE;
    fw        = 1'b0;
    reading   = 16'h0000;
    if (fire) begin
      unique case (rx.payload.mode)
        mspc_pkg::MODE_TICK: begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > timeout_q) begin
            if (pend_q == mspc_pkg::CMD_PPM) begin
              elapsed_d = 16'h0000;
              op        = mspc_pkg::JOB_FRAME;
              if (fail_inc >= poll_limit_q) begin
                // Too many missed readings: start scanning at address zero.
                fail_d  = 8'h00;
                slave_d = 8'h00;
                pend_d  = mspc_pkg::CMD_SCAN;
                fw      = 1'b1;
              end else begin
                fail_d  = fail_inc;
                pend_d  = mspc_pkg::CMD_PPM;
              end
            end else if (pend_q == mspc_pkg::CMD_SCAN) begin
              elapsed_d = 16'h0000;
              if (fail_inc >= scan_limit_q) begin
                fail_d = 8'h00;
                pend_d = mspc_pkg::CMD_NONE;
                op     = mspc_pkg::JOB_NOT_FOUND;
              end else begin
                fail_d  = fail_inc;
                slave_d = fail_inc;
                pend_d  = mspc_pkg::CMD_SCAN;
                op      = mspc_pkg::JOB_FRAME;
                fw      = 1'b1;
              end
            end
          end
        end
        mspc_pkg::MODE_RESPONSE: begin
          if (rx.payload.resp_address != header_q) begin
            warn_d    = 1'b1;
            elapsed_d = 16'h0000;
            pend_d    = mspc_pkg::CMD_PPM;
            op        = mspc_pkg::JOB_FRAME;
          end else begin
            warn_d = 1'b0;
            if (pend_q == mspc_pkg::CMD_PPM) begin
              pend_d    = mspc_pkg::CMD_NONE;
              elapsed_d = 16'h0000;
              op        = mspc_pkg::JOB_READING;
              reading   = {rx.payload.resp_value_high, rx.payload.resp_value_low};
            end else if (pend_q == mspc_pkg::CMD_SCAN) begin
              // Firmware reply found the sensor; ask for a reading next.
              fail_d    = 8'h00;
              elapsed_d = 16'h0000;
              pend_d    = mspc_pkg::CMD_PPM;
              op        = mspc_pkg::JOB_FRAME;
            end else begin
              pend_d    = mspc_pkg::CMD_NONE;
              elapsed_d = 16'h0000;
            end
          end
        end
        mspc_pkg::MODE_POLL: begin
          if (enabled_q && !(pend_active && (elapsed_q < timeout_q))) begin
            elapsed_d = 16'h0000;
            pend_d    = mspc_pkg::CMD_PPM;
            op        = mspc_pkg::JOB_FRAME;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= mspc_pkg::CMD_NONE;
      elapsed_q <= 16'h0000;
      fail_q    <= 8'h00;
      slave_q   <= mspc_pkg::SLAVE_ADDR_RST;
      warn_q    <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      elapsed_q <= elapsed_d;
      fail_q    <= fail_d;
      slave_q   <= slave_d;
      warn_q    <= warn_d;
    end
  end

  assign job_vld_o     = fire && (op != mspc_pkg::JOB_NONE);
  assign job_o.op      = op;
  assign job_o.addr    = slave_d;
  assign job_o.fw      = fw;
  assign job_o.reading = reading;
  assign job_o.warning = warn_d;

endmodule

### src/mspc_frame_tx.sv
// Job holding register followed by the beat sender. A frame job leaves as
// eight beats; the other jobs leave as one beat.
module mspc_frame_tx (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_vld_i,
  input  mspc_pkg::job_t  job_i,
  output logic            slot_free_o,
  mspc_out_if.source      tx
);

  mspc_pkg::job_t slot_q;
  logic           slot_vld_q;
  mspc_pkg::job_t cur_q;
  logic           cur_vld_q;
  logic [2:0]     idx_q;

  logic           cur_last;
  logic           beat_fire;
  logic           advance;
  logic [15:0]    reg_word;
  logic [15:0]    crc;
  logic [7:0]     frame_byte;

  assign cur_last    = (cur_q.op != mspc_pkg::JOB_FRAME) || (idx_q == 3'd7);
  assign beat_fire   = tx.valid && tx.ready;
  assign advance     = !cur_vld_q || (beat_fire && cur_last);
  assign slot_free_o = !slot_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      cur_vld_q  <= 1'b0;
      idx_q      <= 3'd0;
    end else begin
      if (advance) begin
        cur_vld_q <= slot_vld_q;
        idx_q     <= 3'd0;
      end else if (beat_fire) begin
        idx_q <= idx_q + 3'd1;
      end
      if (slot_free_o) begin
        slot_vld_q <= job_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && slot_vld_q) begin
      cur_q <= slot_q;
    end
    if (slot_free_o && job_vld_i) begin
      slot_q <= job_i;
    end
  end

  assign reg_word = cur_q.fw ? mspc_pkg::REG_FIRMWARE : mspc_pkg::REG_PPM;
  assign crc      = (cur_q.fw ? mspc_pkg::CRC_BASE_FW : mspc_pkg::CRC_BASE_PPM)
                    ^ mspc_pkg::crc_addr_term(cur_q.addr);

  // Frame layout: address, function, register, count, CRC low then high.
  always_comb begin
    unique case (idx_q)
      3'd0:    frame_byte = cur_q.addr;
      3'd1:    frame_byte = mspc_pkg::FUNC_READ_INPUT;
      3'd2:    frame_byte = reg_word[15:8];
      3'd3:    frame_byte = reg_word[7:0];
      3'd4:    frame_byte = mspc_pkg::REG_COUNT[15:8];
      3'd5:    frame_byte = mspc_pkg::REG_COUNT[7:0];
      3'd6:    frame_byte = crc[7:0];
      default: frame_byte = crc[15:8];
    endcase
  end

  always_comb begin
    tx.valid           = cur_vld_q;
    tx.payload.last    = cur_last;
    tx.payload.warning = cur_q.warning;
    tx.payload.tx_byte = 8'h00;
    tx.payload.reading = 16'h0000;
    unique case (cur_q.op)
      mspc_pkg::JOB_FRAME: begin
        tx.payload.kind    = mspc_pkg::KIND_TX_BYTE;
        tx.payload.tx_byte = frame_byte;
      end
      mspc_pkg::JOB_READING: begin
        tx.payload.kind    = mspc_pkg::KIND_READING;
        tx.payload.reading = cur_q.reading;
      end
      default: begin
        tx.payload.kind = mspc_pkg::KIND_NOT_FOUND;
      end
    endcase
  end

endmodule

### src/modbus_sensor_poll_controller.sv
// Modbus RTU poll master for a gas sensor.
// Channel rx_i takes one event per beat: a one millisecond tick, the decoded
// fields of a five-byte response, or a poll request. Channel tx_o gives result
// beats: the eight bytes of a read-input-register request frame (last set on
// the CRC high byte), a concentration reading, or a sensor-not-found report.
// Every result beat carries the warning flag as left by its event.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i, one
// register per cycle; the user must write it only while no event is in flight,
// which the block itself does not enforce. An accepted event updates the poll
// state in the same cycle; its results pass through the job holding register
// and the current-job register to tx_o. A frame occupies tx_o for eight beats
// from the single byte sender, so with a ready receiver that sender limits
// frame-producing events, while other events are accepted one per cycle.
// One event's job waits in a holding register, so rx_i keeps accepting while
// a finished beat is stalled on tx_o; once that register is full rx_i stalls.
// Reset restores the register defaults, clears pending request, elapsed time,
// fail count and warning, and sets the slave address to 0x15.
module modbus_sensor_poll_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mspc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mspc_pkg::CfgDataW-1:0]   cfg_data_i,
  mspc_in_if.sink                         rx_i,
  mspc_out_if.source                      tx_o
);

  // Job hand-over between the state update and the beat sender.
  logic           job_vld;
  mspc_pkg::job_t job;
  logic           slot_free;

  mspc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx          (rx_i),
    .slot_free_i (slot_free),
    .job_vld_o   (job_vld),
    .job_o       (job)
  );

  mspc_frame_tx u_frame_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_vld_i   (job_vld),
    .job_i       (job),
    .slot_free_o (slot_free),
    .tx          (tx_o)
  );

  // A job is only produced when the holding register can take it.
  a_job_has_room: assert property (
    @(posedge clk_i) disable iff (!rst_ni) job_vld |-> slot_free
  ) else $error("job produced while the holding register is full");

  // The bytes of a frame follow each other without a gap.
  a_frame_contiguous: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (tx_o.valid && tx_o.ready && !tx_o.payload.last) |=>
      (tx_o.valid && (tx_o.payload.kind == mspc_pkg::KIND_TX_BYTE))
  ) else $error("frame interrupted");

  // Reading and not-found reports are single beats.
  a_single_beat_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (tx_o.valid && (tx_o.payload.kind != mspc_pkg::KIND_TX_BYTE)) |->
      (tx_o.payload.last && (tx_o.payload.tx_byte == 8'h00))
  ) else $error("single-beat result malformed");

endmodule
